@@ hw/rtl/oct_pkg.sv @@
`timescale 1ns / 1ps

package oct_pkg;

    // Default number of rows in the command table.
    localparam int unsigned OCT_TABLE_DEPTH = 16;

    // Opcodes of an input item.
    localparam logic [1:0] OP_SEND = 2'd0;
    localparam logic [1:0] OP_ACK  = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;
    localparam logic [1:0] OP_NOP  = 2'd3;

    // Status codes of a result item.
    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_UPDATED   = 3'd1;
    localparam logic [2:0] ST_ACKED     = 3'd2;
    localparam logic [2:0] ST_NO_MATCH  = 3'd3;
    localparam logic [2:0] ST_ROW_READ  = 3'd4;
    localparam logic [2:0] ST_ROW_EMPTY = 3'd5;

    // One row of the table, stored as one word of the table memory.
    typedef struct packed {
        logic [15:0] id;
        logic [31:0] command;
        logic [31:0] sent_time;
        logic        acked;
        logic [31:0] ack_time;
    } row_t;

    // Control from the sequencer to the compare unit.
    typedef struct packed {
        logic clear;
        logic check;
        logic ack_mode;
    } scan_ctl_t;

    // Flags from the compare unit back to the sequencer.
    typedef struct packed {
        logic hit;
        logic any_acked;
    } scan_flags_t;

    // Everything one result item carries.
    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  row_touched;
        logic        did_evict;
        logic [15:0] evicted_id;
        logic        resend_after_ack;
        logic        command_differs;
        logic [4:0]  entry_count;
        row_t        row;
    } result_t;

endpackage

@@ hw/rtl/oct_ram.sv @@
`timescale 1ns / 1ps

module oct_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hw/rtl/oct_scan.sv @@
`timescale 1ns / 1ps

module oct_scan import oct_pkg::*; #(
    parameter int unsigned TABLE_DEPTH = OCT_TABLE_DEPTH,
    localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  scan_ctl_t         ctl,
    input  logic [AW-1:0]     chk_idx,
    input  row_t              row,
    input  logic [15:0]       key,
    output scan_flags_t       flags,
    output logic [AW-1:0]     acked_idx,
    output logic [15:0]       acked_id,
    output logic [15:0]       last_id
);

    logic          any_acked_reg;
    logic [AW-1:0] acked_idx_reg;
    logic [15:0]   acked_id_reg;
    logic [15:0]   last_id_reg;
    logic          id_eq;

    // An acknowledge only matches a row that is still waiting for one.
    assign id_eq     = (row.id == key);
    assign flags.hit = ctl.check && id_eq && !(ctl.ack_mode && row.acked);
    assign flags.any_acked = any_acked_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            any_acked_reg <= 1'b0;
        end
        else if (ctl.clear)
        begin
            any_acked_reg <= 1'b0;
        end
        else if (ctl.check && row.acked)
        begin
            any_acked_reg <= 1'b1;
        end
    end

    // Rows are checked newest first, so the last acknowledged row seen is the oldest one.
    always_ff @(posedge clk)
    begin
        if (ctl.check && row.acked)
        begin
            acked_idx_reg <= chk_idx;
            acked_id_reg  <= row.id;
        end
        if (ctl.check)
        begin
            last_id_reg <= row.id;
        end
    end

    assign acked_idx = acked_idx_reg;
    assign acked_id  = acked_id_reg;
    assign last_id   = last_id_reg;

endmodule

@@ hw/rtl/outstanding_command_tracker_core.sv @@
`timescale 1ns / 1ps
// A read of a valid row fetches it from the table memory, a read past the valid rows or a
// no-operation goes straight to the result, an acknowledge or update scans for its row and
// rewrites it if found, and an insert scans every valid row and then shifts rows down to
// open row 0. The scan reads one row per cycle through the single read port of the table
// memory. Throughput: one item at a time, cmd_stall is low only between items. Reset clears
// the row count and the control state; table contents are not cleared.
module outstanding_command_tracker_core import oct_pkg::*; #(
    parameter int unsigned TABLE_DEPTH = OCT_TABLE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    // Command channel.
    input  logic        cmd_valid,
    output logic        cmd_stall,
    input  logic [1:0]  opcode,
    input  logic [15:0] uplink_id,
    input  logic [31:0] command_code,
    input  logic [31:0] time_stamp,
    input  logic [3:0]  row_select,
    // Response channel.
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output logic [2:0]  status,
    output logic [3:0]  row_touched,
    output logic        did_evict,
    output logic [15:0] evicted_id,
    output logic        resend_after_ack,
    output logic        command_differs,
    output logic [4:0]  entry_count,
    output logic [15:0] row_id,
    output logic [31:0] row_command,
    output logic [31:0] row_sent_time,
    output logic        row_acked,
    output logic [31:0] row_ack_time
);

    // Row index width, row count width, and a width that holds both a count and row_select.
    localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
    localparam int unsigned SW = (CW > 4) ? CW : 4;

    // The sequencer. SCAN walks the rows newest first through the compare unit; SHIFT moves
    // rows down by one to open row 0; INSERT writes the new row; HIT rewrites a matched row;
    // RDWAIT collects a read row; FINISH hands the item's result to the output register.
    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_SCAN   = 7'b0000010,
        S_SHIFT  = 7'b0000100,
        S_INSERT = 7'b0001000,
        S_HIT    = 7'b0010000,
        S_RDWAIT = 7'b0100000,
        S_FINISH = 7'b1000000
    } state_t;

    state_t         state_reg, state_next;
    logic [1:0]     op_reg, op_next;
    logic [15:0]    id_reg, id_next;
    logic [31:0]    code_reg, code_next;
    logic [31:0]    ts_reg, ts_next;
    logic [CW-1:0]  count_reg, count_next;
    logic [CW-1:0]  issue_reg, issue_next;
    logic           pend_reg, pend_next;
    logic [AW-1:0]  chk_idx_reg, chk_idx_next;
    logic [AW-1:0]  hit_idx_reg, hit_idx_next;
    row_t           hit_row_reg, hit_row_next;
    logic [CW-1:0]  sh_left_reg, sh_left_next;
    logic           wpend_reg, wpend_next;
    logic [AW-1:0]  waddr_reg, waddr_next;
    logic           evict_reg, evict_next;
    result_t        res_reg, res_next;
    result_t        rsp_reg, rsp_next;
    logic           rsp_valid_reg, rsp_valid_next;

    logic           cmd_accept;
    logic [SW-1:0]  sel_w;
    logic [SW-1:0]  count_w;
    logic           sel_in_range;
    logic [CW-1:0]  sh_dec;
    logic [AW+3:0]  hit_idx_w;
    logic [CW+4:0]  count_ext;
    logic           table_full;
    row_t           new_row;
    result_t        res_final;

    logic           ram_we;
    logic [AW-1:0]  ram_waddr;
    row_t           ram_wdata;
    logic           ram_re;
    logic [AW-1:0]  ram_raddr;
    row_t           ram_rdata;

    scan_ctl_t      scan_ctl;
    scan_flags_t    scan_flags;
    logic [AW-1:0]  scan_acked_idx;
    logic [15:0]    scan_acked_id;
    logic [15:0]    scan_last_id;

    // All rows of the table live in one memory word each.
    oct_ram #(
        .WIDTH ($bits(row_t)),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .we      (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // The shared compare unit sees one row per cycle and also remembers the oldest
    // acknowledged row and the oldest row, which are the eviction candidates.
    oct_scan #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (scan_ctl),
        .chk_idx   (chk_idx_reg),
        .row       (ram_rdata),
        .key       (id_reg),
        .flags     (scan_flags),
        .acked_idx (scan_acked_idx),
        .acked_id  (scan_acked_id),
        .last_id   (scan_last_id)
    );

    assign cmd_stall  = (state_reg != S_IDLE);
    assign cmd_accept = cmd_valid && !cmd_stall;

    // A read is served only for rows that hold an entry; row_select is four bits wide,
    // so a deeper table can only be read in its first sixteen rows.
    assign sel_w        = SW'(row_select);
    assign count_w      = SW'(count_reg);
    assign sel_in_range = (sel_w < count_w);

    assign sh_dec     = sh_left_reg - CW'(1);
    assign hit_idx_w  = {4'b0000, hit_idx_reg};
    assign count_ext  = {5'b00000, count_reg};
    assign table_full = (count_reg == CW'(TABLE_DEPTH));

    always_comb
    begin
        new_row           = '0;
        new_row.id        = id_reg;
        new_row.command   = code_reg;
        new_row.sent_time = ts_reg;
    end

    // The row count goes out as it stands when the result is handed over.
    always_comb
    begin
        res_final             = res_reg;
        res_final.entry_count = count_ext[4:0];
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        id_next        = id_reg;
        code_next      = code_reg;
        ts_next        = ts_reg;
        count_next     = count_reg;
        issue_next     = issue_reg;
        pend_next      = pend_reg;
        chk_idx_next   = chk_idx_reg;
        hit_idx_next   = hit_idx_reg;
        hit_row_next   = hit_row_reg;
        sh_left_next   = sh_left_reg;
        wpend_next     = wpend_reg;
        waddr_next     = waddr_reg;
        evict_next     = evict_reg;
        res_next       = res_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;

        ram_we    = 1'b0;
        ram_waddr = waddr_reg;
        ram_wdata = ram_rdata;
        ram_re    = 1'b0;
        ram_raddr = '0;
        scan_ctl  = '0;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                scan_ctl.clear = 1'b1;
                if (cmd_accept)
                begin
                    op_next         = opcode;
                    id_next         = uplink_id;
                    code_next       = command_code;
                    ts_next         = time_stamp;
                    issue_next      = '0;
                    pend_next       = 1'b0;
                    evict_next      = 1'b0;
                    res_next        = '0;
                    res_next.status = ST_ROW_EMPTY;
                    case (opcode) inside
                        OP_SEND, OP_ACK:
                        begin
                            state_next = S_SCAN;
                        end
                        OP_READ:
                        begin
                            res_next.row_touched = row_select;
                            if (sel_in_range)
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = sel_w[AW-1:0];
                                state_next = S_RDWAIT;
                            end
                            else
                            begin
                                state_next = S_FINISH;
                            end
                        end
                        default:
                        begin
                            state_next = S_FINISH;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                // The row read last cycle is checked while the next one is read.
                scan_ctl.check    = pend_reg;
                scan_ctl.ack_mode = (op_reg == OP_ACK);
                if (scan_flags.hit)
                begin
                    hit_idx_next = chk_idx_reg;
                    hit_row_next = ram_rdata;
                    state_next   = S_HIT;
                end
                else if (issue_reg < count_reg)
                begin
                    ram_re       = 1'b1;
                    ram_raddr    = issue_reg[AW-1:0];
                    issue_next   = issue_reg + CW'(1);
                    pend_next    = 1'b1;
                    chk_idx_next = issue_reg[AW-1:0];
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        // Every valid row was checked without a match.
                        if (op_reg == OP_ACK)
                        begin
                            res_next.status = ST_NO_MATCH;
                            state_next      = S_FINISH;
                        end
                        else
                        begin
                            // With a full table the victim row is dropped by letting the
                            // rows above it slide down over it; rows below it stay put.
                            wpend_next = 1'b0;
                            if (table_full)
                            begin
                                evict_next         = 1'b1;
                                res_next.did_evict = 1'b1;
                                if (scan_flags.any_acked)
                                begin
                                    res_next.evicted_id = scan_acked_id;
                                    sh_left_next        = CW'(scan_acked_idx);
                                end
                                else
                                begin
                                    res_next.evicted_id = scan_last_id;
                                    sh_left_next        = count_reg - CW'(1);
                                end
                            end
                            else
                            begin
                                sh_left_next = count_reg;
                            end
                            state_next = S_SHIFT;
                        end
                    end
                end
            end

            S_SHIFT:
            begin
                // Row i-1 is read in one cycle and written to row i in the next.
                if (wpend_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = waddr_reg;
                    ram_wdata = ram_rdata;
                end
                if (sh_left_reg != '0)
                begin
                    ram_re       = 1'b1;
                    ram_raddr    = sh_dec[AW-1:0];
                    waddr_next   = sh_left_reg[AW-1:0];
                    wpend_next   = 1'b1;
                    sh_left_next = sh_dec;
                end
                else
                begin
                    wpend_next = 1'b0;
                    state_next = S_INSERT;
                end
            end

            S_INSERT:
            begin
                ram_we    = 1'b1;
                ram_waddr = '0;
                ram_wdata = new_row;
                if (!evict_reg)
                begin
                    count_next = count_reg + CW'(1);
                end
                res_next.status      = ST_INSERTED;
                res_next.row_touched = 4'd0;
                state_next           = S_FINISH;
            end

            S_HIT:
            begin
                ram_we    = 1'b1;
                ram_waddr = hit_idx_reg;
                ram_wdata = hit_row_reg;
                res_next.row_touched = hit_idx_w[3:0];
                if (op_reg == OP_SEND)
                begin
                    ram_wdata.command        = code_reg;
                    ram_wdata.sent_time      = ts_reg;
                    ram_wdata.acked          = 1'b0;
                    ram_wdata.ack_time       = '0;
                    res_next.status           = ST_UPDATED;
                    res_next.resend_after_ack = hit_row_reg.acked;
                    res_next.command_differs  = (hit_row_reg.command != code_reg);
                end
                else
                begin
                    ram_wdata.acked    = 1'b1;
                    ram_wdata.ack_time = ts_reg;
                    res_next.status    = ST_ACKED;
                end
                state_next = S_FINISH;
            end

            S_RDWAIT:
            begin
                res_next.status = ST_ROW_READ;
                res_next.row    = ram_rdata;
                if (!ram_rdata.acked)
                begin
                    res_next.row.ack_time = '0;
                end
                state_next = S_FINISH;
            end

            S_FINISH:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next       = res_final;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            issue_reg     <= '0;
            pend_reg      <= 1'b0;
            sh_left_reg   <= '0;
            wpend_reg     <= 1'b0;
            evict_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            issue_reg     <= issue_next;
            pend_reg      <= pend_next;
            sh_left_reg   <= sh_left_next;
            wpend_reg     <= wpend_next;
            evict_reg     <= evict_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        id_reg      <= id_next;
        code_reg    <= code_next;
        ts_reg      <= ts_next;
        chk_idx_reg <= chk_idx_next;
        hit_idx_reg <= hit_idx_next;
        hit_row_reg <= hit_row_next;
        waddr_reg   <= waddr_next;
        res_reg     <= res_next;
        rsp_reg     <= rsp_next;
    end

    assign rsp_valid        = rsp_valid_reg;
    assign status           = rsp_reg.status;
    assign row_touched      = rsp_reg.row_touched;
    assign did_evict        = rsp_reg.did_evict;
    assign evicted_id       = rsp_reg.evicted_id;
    assign resend_after_ack = rsp_reg.resend_after_ack;
    assign command_differs  = rsp_reg.command_differs;
    assign entry_count      = rsp_reg.entry_count;
    assign row_id           = rsp_reg.row.id;
    assign row_command      = rsp_reg.row.command;
    assign row_sent_time    = rsp_reg.row.sent_time;
    assign row_acked        = rsp_reg.row.acked;
    assign row_ack_time     = rsp_reg.row.ack_time;

    // The compare unit reports a match only while the sequencer is scanning.
    a_hit_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        scan_flags.hit |-> state_reg == S_SCAN)
        else $error("compare unit hit outside of a scan");

    // No table write ever lands beyond the row just past the valid rows.
    a_write_in_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> CW'(ram_waddr) <= count_reg)
        else $error("table write beyond the valid rows");

    // An insert without eviction grows the table by exactly one row.
    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_INSERT && !evict_reg) |=> count_reg == $past(count_reg) + CW'(1))
        else $error("insert did not grow the row count by one");

    // An eviction happens only with a full table, and the count stays full.
    a_evict_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_INSERT && evict_reg) |-> count_reg == CW'(TABLE_DEPTH))
        else $error("eviction with a table that is not full");

endmodule

@@ tb/outstanding_command_tracker_checker.sv @@
`timescale 1ns / 1ps

module outstanding_command_tracker_checker import oct_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    input  logic        cmd_stall,
    input  logic [1:0]  opcode,
    input  logic [15:0] uplink_id,
    input  logic [31:0] command_code,
    input  logic [31:0] time_stamp,
    input  logic [3:0]  row_select,
    input  logic        rsp_valid,
    input  logic        rsp_stall,
    input  logic [2:0]  status,
    input  logic [3:0]  row_touched,
    input  logic        did_evict,
    input  logic [15:0] evicted_id,
    input  logic        resend_after_ack,
    input  logic        command_differs,
    input  logic [4:0]  entry_count,
    input  logic [15:0] row_id,
    input  logic [31:0] row_command,
    input  logic [31:0] row_sent_time,
    input  logic        row_acked,
    input  logic [31:0] row_ack_time,
    output int unsigned failures,
    output int unsigned pending,
    output int unsigned results_checked
);

    localparam int unsigned DEPTH = OCT_TABLE_DEPTH;

    // Shadow copy of the command table, newest row first.
    row_t        shadow_rows [DEPTH];
    int unsigned shadow_count;
    result_t     predicted_responses [$];

    task automatic track_command(input logic [1:0] op, input logic [15:0] id,
                                 input logic [31:0] code, input logic [31:0] ts,
                                 input logic [3:0] sel, output result_t r);
        int unsigned i;
        int unsigned victim;
        bit          found;
        r = '0;
        r.status = ST_ROW_EMPTY;
        found = 1'b0;
        case (op)
            OP_SEND:
            begin
                for (i = 0; i < shadow_count; i++)
                begin
                    if (!found && shadow_rows[i].id == id)
                    begin
                        r.resend_after_ack = shadow_rows[i].acked;
                        r.command_differs  = (shadow_rows[i].command != code);
                        shadow_rows[i].command   = code;
                        shadow_rows[i].sent_time = ts;
                        shadow_rows[i].acked     = 1'b0;
                        shadow_rows[i].ack_time  = '0;
                        r.status      = ST_UPDATED;
                        r.row_touched = i[3:0];
                        found = 1'b1;
                    end
                end
                if (!found)
                begin
                    if (shadow_count >= DEPTH)
                    begin
                        // The oldest acknowledged row goes first, else the oldest row.
                        victim = shadow_count - 1;
                        for (i = shadow_count; i > 0; i--)
                        begin
                            if (!found && shadow_rows[i - 1].acked)
                            begin
                                victim = i - 1;
                                found = 1'b1;
                            end
                        end
                        r.did_evict  = 1'b1;
                        r.evicted_id = shadow_rows[victim].id;
                        for (i = victim; i + 1 < shadow_count; i++)
                            shadow_rows[i] = shadow_rows[i + 1];
                        shadow_count--;
                    end
                    for (i = shadow_count; i > 0; i--)
                        shadow_rows[i] = shadow_rows[i - 1];
                    shadow_rows[0] = '{id: id, command: code, sent_time: ts,
                                       acked: 1'b0, ack_time: '0};
                    shadow_count++;
                    r.status      = ST_INSERTED;
                    r.row_touched = '0;
                end
            end
            OP_ACK:
            begin
                r.status = ST_NO_MATCH;
                for (i = 0; i < shadow_count; i++)
                begin
                    if (!found && shadow_rows[i].id == id && !shadow_rows[i].acked)
                    begin
                        shadow_rows[i].acked    = 1'b1;
                        shadow_rows[i].ack_time = ts;
                        r.status      = ST_ACKED;
                        r.row_touched = i[3:0];
                        found = 1'b1;
                    end
                end
            end
            OP_READ:
            begin
                r.row_touched = sel;
                if (sel < shadow_count)
                begin
                    r.status = ST_ROW_READ;
                    r.row    = shadow_rows[sel];
                    if (!r.row.acked)
                        r.row.ack_time = '0;
                end
            end
            default:
            begin
            end
        endcase
        r.entry_count = shadow_count[4:0];
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            failures++;
            if (failures <= 10)
                $display("Mismatch in result %0d, %s: expected %0h, got %0h",
                         results_checked, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        result_t want;
        result_t got;
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
            begin
                got.status           = status;
                got.row_touched      = row_touched;
                got.did_evict        = did_evict;
                got.evicted_id       = evicted_id;
                got.resend_after_ack = resend_after_ack;
                got.command_differs  = command_differs;
                got.entry_count      = entry_count;
                got.row.id           = row_id;
                got.row.command      = row_command;
                got.row.sent_time    = row_sent_time;
                got.row.acked        = row_acked;
                got.row.ack_time     = row_ack_time;
                if (predicted_responses.size() == 0)
                begin
                    failures++;
                    if (failures <= 10)
                        $display("Result %0d arrived with nothing predicted, status %0d",
                                 results_checked, status);
                end
                else
                begin
                    want = predicted_responses.pop_front();
                    check_field("status", 32'(want.status), 32'(got.status));
                    check_field("row_touched", 32'(want.row_touched), 32'(got.row_touched));
                    check_field("did_evict", 32'(want.did_evict), 32'(got.did_evict));
                    check_field("evicted_id", 32'(want.evicted_id), 32'(got.evicted_id));
                    check_field("resend_after_ack", 32'(want.resend_after_ack),
                                32'(got.resend_after_ack));
                    check_field("command_differs", 32'(want.command_differs),
                                32'(got.command_differs));
                    check_field("entry_count", 32'(want.entry_count), 32'(got.entry_count));
                    check_field("row_id", 32'(want.row.id), 32'(got.row.id));
                    check_field("row_command", want.row.command, got.row.command);
                    check_field("row_sent_time", want.row.sent_time, got.row.sent_time);
                    check_field("row_acked", 32'(want.row.acked), 32'(got.row.acked));
                    check_field("row_ack_time", want.row.ack_time, got.row.ack_time);
                end
                results_checked++;
            end
            if (cmd_valid && !cmd_stall)
            begin
                track_command(opcode, uplink_id, command_code, time_stamp, row_select, want);
                predicted_responses.push_back(want);
            end
            pending = predicted_responses.size();
        end
    end

endmodule

@@ tb/tb_outstanding_command_tracker_core.sv @@
`timescale 1ns / 1ps

module tb_outstanding_command_tracker_core;
    import oct_pkg::*;

    // A run that accepts nothing on either channel for this many cycles is hung.
    // Neither the worst single item with its result stalls nor the longest
    // deliberate receiver hold-off, HOLD_OFF_CYCLES, comes near this limit.
    localparam int unsigned IDLE_LIMIT      = 3000;
    localparam int unsigned HOLD_OFF_CYCLES = 400;
    // Cycles to watch for stray results once every prediction has been met.
    localparam int unsigned TAIL_CYCLES     = 2 * OCT_TABLE_DEPTH + 32;
    localparam int unsigned PHASE_ITEMS     = 410;
    localparam int unsigned POOL_SIZE       = 40;

    logic        clk;
    logic        rst_n;
    logic        cmd_valid;
    logic        cmd_stall;
    logic [1:0]  opcode;
    logic [15:0] uplink_id;
    logic [31:0] command_code;
    logic [31:0] time_stamp;
    logic [3:0]  row_select;
    logic        rsp_valid;
    logic        rsp_stall;
    logic [2:0]  status;
    logic [3:0]  row_touched;
    logic        did_evict;
    logic [15:0] evicted_id;
    logic        resend_after_ack;
    logic        command_differs;
    logic [4:0]  entry_count;
    logic [15:0] row_id;
    logic [31:0] row_command;
    logic [31:0] row_sent_time;
    logic        row_acked;
    logic [31:0] row_ack_time;

    int unsigned failures;
    int unsigned pending;
    int unsigned results_checked;

    // Idle rates in percent, changed per phase by the stimulus process.
    int unsigned send_idle_pct;
    int unsigned rsp_stall_pct;
    // Raising this bit asks the receiver process for one long hold-off.
    bit          hold_off_request;

    // Ids that the random part draws from, so that sends, resends and
    // acknowledges hit the same rows, plus the last code sent with each.
    logic [15:0] id_pool   [POOL_SIZE];
    logic [31:0] last_code [POOL_SIZE];
    int unsigned op_items  [4];

    outstanding_command_tracker_core dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd_valid        (cmd_valid),
        .cmd_stall        (cmd_stall),
        .opcode           (opcode),
        .uplink_id        (uplink_id),
        .command_code     (command_code),
        .time_stamp       (time_stamp),
        .row_select       (row_select),
        .rsp_valid        (rsp_valid),
        .rsp_stall        (rsp_stall),
        .status           (status),
        .row_touched      (row_touched),
        .did_evict        (did_evict),
        .evicted_id       (evicted_id),
        .resend_after_ack (resend_after_ack),
        .command_differs  (command_differs),
        .entry_count      (entry_count),
        .row_id           (row_id),
        .row_command      (row_command),
        .row_sent_time    (row_sent_time),
        .row_acked        (row_acked),
        .row_ack_time     (row_ack_time)
    );

    // The checker sees both channels exactly as the block does, keeps its own
    // copy of the table and hands back the failure and outstanding counts.
    outstanding_command_tracker_checker response_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd_valid        (cmd_valid),
        .cmd_stall        (cmd_stall),
        .opcode           (opcode),
        .uplink_id        (uplink_id),
        .command_code     (command_code),
        .time_stamp       (time_stamp),
        .row_select       (row_select),
        .rsp_valid        (rsp_valid),
        .rsp_stall        (rsp_stall),
        .status           (status),
        .row_touched      (row_touched),
        .did_evict        (did_evict),
        .evicted_id       (evicted_id),
        .resend_after_ack (resend_after_ack),
        .command_differs  (command_differs),
        .entry_count      (entry_count),
        .row_id           (row_id),
        .row_command      (row_command),
        .row_sent_time    (row_sent_time),
        .row_acked        (row_acked),
        .row_ack_time     (row_ack_time),
        .failures         (failures),
        .pending          (pending),
        .results_checked  (results_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Receiver side. It is the only process that drives rsp_stall. A hold-off
    // request is counted down here so that the sender keeps offering items
    // meanwhile and the block has to stall its command channel.
    initial
    begin
        int unsigned hold_left;
        bit          hold_taken;
        hold_left  = 0;
        hold_taken = 1'b0;
        rsp_stall  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_request && !hold_taken)
            begin
                hold_left  = HOLD_OFF_CYCLES;
                hold_taken = 1'b1;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                rsp_stall <= 1'b1;
            end
            else
                rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
        end
    end

    // Watchdog. Any accepted item on either channel restarts the count.
    initial
    begin
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        @(posedge rst_n);
        while (quiet_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Timeout: no item accepted for %0d cycles", IDLE_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    // Offer one command item and hold it until the block takes it. Valid is
    // only lowered for a random idle cycle, so back-to-back items keep it high.
    task automatic send_item(input logic [1:0] op, input logic [15:0] id,
                             input logic [31:0] code, input logic [31:0] ts,
                             input logic [3:0] sel);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(negedge clk);
        end
        cmd_valid    <= 1'b1;
        opcode       <= op;
        uplink_id    <= id;
        command_code <= code;
        time_stamp   <= ts;
        row_select   <= sel;
        do
            @(posedge clk);
        while (cmd_stall);
        op_items[op]++;
    endtask

    // Stop offering items until every predicted result has been checked.
    task automatic wait_for_results;
        @(negedge clk);
        cmd_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    // Fresh ids for the first used slots of the pool. A small pool keeps the
    // table full and makes resends and matching acknowledges common; a larger
    // one forces evictions.
    task automatic refill_pool(input int unsigned used);
        for (int k = 0; k < used; k++)
        begin
            id_pool[k]   = 16'($urandom_range(16'hFFFF));
            last_code[k] = $urandom;
        end
    endtask

    // One random item. The weights decide how often sends, acknowledges and
    // reads occur; a few percent of the items are pure noise with any opcode,
    // including the no-operation code, and ids from outside the pool.
    task automatic random_item(input int unsigned send_w, input int unsigned ack_w,
                               input int unsigned pool_used);
        int unsigned roll;
        int unsigned slot;
        logic [1:0]  op;
        logic [15:0] id;
        logic [31:0] code;
        roll = $urandom_range(99);
        slot = $urandom_range(pool_used - 1);
        id   = id_pool[slot];
        code = $urandom;
        if (roll < 5)
        begin
            op = 2'($urandom_range(3));
            id = 16'($urandom_range(16'hFFFF));
        end
        else
        begin
            roll = $urandom_range(99);
            if (roll < send_w)
            begin
                op = OP_SEND;
                // Half the resends keep the code, so both values of
                // command_differs show up.
                if ($urandom_range(1))
                    code = last_code[slot];
                last_code[slot] = code;
            end
            else if (roll < send_w + ack_w)
                op = OP_ACK;
            else
                op = OP_READ;
        end
        send_item(op, id, code, $urandom, 4'($urandom_range(15)));
    endtask

    initial
    begin
        cmd_valid        = 1'b0;
        opcode           = OP_NOP;
        uplink_id        = '0;
        command_code     = '0;
        time_stamp       = '0;
        row_select       = '0;
        send_idle_pct    = 9;
        rsp_stall_pct    = 67;
        hold_off_request = 1'b0;
        for (int k = 0; k < 4; k++)
            op_items[k] = 0;
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part. An empty table first: a read past the valid rows, an
        // acknowledge that matches nothing and a no-operation item.
        send_item(OP_READ, 16'h0000, 32'h0, 32'h0, 4'd0);
        send_item(OP_ACK, 16'h1234, 32'h0, 32'h0000_0042, 4'd0);
        send_item(OP_NOP, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF);
        // Extreme field values, then read the newest row back.
        send_item(OP_SEND, 16'h0000, 32'h0000_0000, 32'h0000_0000, 4'd0);
        send_item(OP_SEND, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF);
        send_item(OP_READ, 16'h0000, 32'h0, 32'h0, 4'd0);
        // Acknowledge the newest row and see the acknowledge time in a read.
        send_item(OP_ACK, 16'hFFFF, 32'h0, 32'hFFFF_FFFF, 4'd0);
        send_item(OP_READ, 16'h0000, 32'h0, 32'h0, 4'd0);
        // A resend of an acknowledged id with the same code, then a resend of
        // an unacknowledged id with a different code.
        send_item(OP_SEND, 16'hFFFF, 32'hFFFF_FFFF, 32'h1111_1111, 4'd0);
        send_item(OP_SEND, 16'h0000, 32'h5A5A_5A5A, 32'h2222_2222, 4'd0);
        // Fill the table, then one more new id forces out the oldest row,
        // since no row is acknowledged at this point. Read the last row.
        for (int k = 0; k < OCT_TABLE_DEPTH - 2; k++)
            send_item(OP_SEND, 16'(16'h0100 + k), $urandom, $urandom, 4'd0);
        send_item(OP_SEND, 16'h0200, 32'hA5A5_A5A5, 32'h3333_3333, 4'd0);
        send_item(OP_READ, 16'h0000, 32'h0, 32'h0, 4'hF);
        wait_for_results();

        // Phase A: the receiver stalls often, acknowledges are frequent, so
        // evictions mostly remove an acknowledged row.
        refill_pool(POOL_SIZE);
        for (int n = 0; n < PHASE_ITEMS; n++)
            random_item(40, 40, 20);
        wait_for_results();

        // Phase B: the sender idles often. Few acknowledges and a wide pool
        // make the table fill with unacknowledged rows. Halfway through, the
        // receiver holds off for a long stretch.
        send_idle_pct = 67;
        rsp_stall_pct = 9;
        refill_pool(POOL_SIZE);
        for (int n = 0; n < PHASE_ITEMS; n++)
        begin
            if (n == PHASE_ITEMS / 2)
                hold_off_request = 1'b1;
            random_item(70, 8, POOL_SIZE);
        end
        wait_for_results();

        // Phase C: neither side idles, balanced mix.
        send_idle_pct = 0;
        rsp_stall_pct = 0;
        refill_pool(POOL_SIZE);
        for (int n = 0; n < PHASE_ITEMS; n++)
            random_item(50, 25, 24);
        wait_for_results();

        // Any result that still turns up now has no prediction and counts as
        // a failure in the checker.
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("Covered %0d items: %0d sends, %0d acknowledges, %0d reads, %0d no-ops",
                 op_items[OP_SEND] + op_items[OP_ACK] + op_items[OP_READ] + op_items[OP_NOP],
                 op_items[OP_SEND], op_items[OP_ACK], op_items[OP_READ], op_items[OP_NOP]);
        $display("Checked %0d results over three stall mixes and a %0d-cycle hold-off",
                 results_checked, HOLD_OFF_CYCLES);
        if (failures == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
